[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define SKA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define SKA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/ska_pkg.sv]
package ska_pkg;

    localparam int KEY_W         = 31;
    localparam int PAYLOAD_W     = 31;
    localparam int ENTRY_W       = KEY_W + PAYLOAD_W;
    localparam int INDEX_OUT_W   = 8;
    localparam int COUNT_OUT_W   = 9;
    localparam int DEFAULT_DEPTH = 256;

    typedef enum logic [1:0] {
        FUNC_LOOKUP = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_DELETE = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_DUPLICATE = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_COMPARE,
        ST_DECIDE,
        ST_SHIFT,
        ST_FINISH,
        ST_RESP
    } state_t;

    typedef struct packed {
        func_t                func;
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload_in;
    } req_t;

    typedef struct packed {
        status_t                status;
        logic [INDEX_OUT_W-1:0] found_index;
        logic [PAYLOAD_W-1:0]   found_payload;
        logic [COUNT_OUT_W-1:0] count_out;
    } res_t;

endpackage

[rtl/core/ska_ram.sv]
module ska_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/core/ska_engine.sv]
module ska_engine #(
    parameter int TABLE_DEPTH = ska_pkg::DEFAULT_DEPTH,
    localparam int IW = $clog2(TABLE_DEPTH),
    localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     req_valid,
    output logic                     req_ready,
    input  ska_pkg::req_t            req,
    output logic                     res_valid,
    input  logic                     res_ready,
    output ska_pkg::res_t            res,
    output logic                     mem_rd_en,
    output logic [IW-1:0]            mem_rd_addr,
    input  logic [ska_pkg::ENTRY_W-1:0] mem_rd_data,
    output logic                     mem_wr_en,
    output logic [IW-1:0]            mem_wr_addr,
    output logic [ska_pkg::ENTRY_W-1:0] mem_wr_data
);

    import ska_pkg::*;

    state_t               state_reg, state_next;
    func_t                func_reg, func_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [PAYLOAD_W-1:0] pl_reg, pl_next;
    logic [CW-1:0]        lo_reg, lo_next;
    logic [CW-1:0]        hi_reg, hi_next;
    logic [CW-1:0]        pos_reg, pos_next;
    logic [CW-1:0]        ptr_reg, ptr_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [IW-1:0]        mid_reg, mid_next;
    logic [IW-1:0]        dst_reg, dst_next;
    logic                 hit_reg, hit_next;
    logic                 pend_reg, pend_next;
    status_t              st_reg, st_next;
    logic [PAYLOAD_W-1:0] fpay_reg, fpay_next;

    logic [CW-1:0]        mid_w;
    logic [CW-1:0]        mid_ext;
    logic                 range_open;
    logic [KEY_W-1:0]     rd_key;
    logic [PAYLOAD_W-1:0] rd_pay;
    logic                 is_insert;
    logic                 shift_more;
    logic [CW-1:0]        shift_src;
    logic [31:0]          pos_wide;
    logic [31:0]          count_wide;

    assign mid_w      = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign mid_ext    = CW'(mid_reg);
    assign range_open = lo_reg < hi_reg;
    assign rd_key     = mem_rd_data[KEY_W-1:0];
    assign rd_pay     = mem_rd_data[ENTRY_W-1:KEY_W];
    assign is_insert  = func_reg == FUNC_INSERT;
    assign shift_more = is_insert ? (ptr_reg > pos_reg) : (CW'(ptr_reg + 1'b1) < count_reg);
    assign shift_src  = is_insert ? CW'(ptr_reg - 1'b1) : CW'(ptr_reg + 1'b1);
    assign pos_wide   = 32'(pos_reg);
    assign count_wide = 32'(count_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (req_valid) begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                state_next = range_open ? ST_COMPARE : ST_DECIDE;
            end
            ST_COMPARE: begin
                state_next = (rd_key == key_reg) ? ST_DECIDE : ST_SEARCH;
            end
            ST_DECIDE: begin
                case (func_reg)
                    FUNC_INSERT: begin
                        if (!hit_reg && count_reg != CW'(TABLE_DEPTH)) begin
                            state_next = ST_SHIFT;
                        end else begin
                            state_next = ST_RESP;
                        end
                    end
                    FUNC_DELETE: begin
                        state_next = hit_reg ? ST_SHIFT : ST_RESP;
                    end
                    default: begin
                        state_next = ST_RESP;
                    end
                endcase
            end
            ST_SHIFT: begin
                if (!shift_more && !pend_reg) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        req_ready   = 1'b0;
        res_valid   = 1'b0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = '0;
        mem_wr_data = '0;
        case (state_reg)
            ST_IDLE: begin
                req_ready = 1'b1;
            end
            ST_SEARCH: begin
                mem_rd_en   = range_open;
                mem_rd_addr = mid_w[IW-1:0];
            end
            ST_SHIFT: begin
                mem_rd_en   = shift_more;
                mem_rd_addr = shift_src[IW-1:0];
                mem_wr_en   = pend_reg;
                mem_wr_addr = dst_reg;
                mem_wr_data = mem_rd_data;
            end
            ST_FINISH: begin
                mem_wr_en   = is_insert;
                mem_wr_addr = pos_reg[IW-1:0];
                mem_wr_data = {pl_reg, key_reg};
            end
            ST_RESP: begin
                res_valid = 1'b1;
            end
            default: begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        func_next  = func_reg;
        key_next   = key_reg;
        pl_next    = pl_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        pos_next   = pos_reg;
        ptr_next   = ptr_reg;
        count_next = count_reg;
        mid_next   = mid_reg;
        dst_next   = dst_reg;
        hit_next   = hit_reg;
        pend_next  = pend_reg;
        st_next    = st_reg;
        fpay_next  = fpay_reg;
        case (state_reg)
            ST_IDLE: begin
                if (req_valid) begin
                    func_next = req.func;
                    key_next  = req.key;
                    pl_next   = req.payload_in;
                    lo_next   = '0;
                    hi_next   = count_reg;
                    hit_next  = 1'b0;
                end
            end
            ST_SEARCH: begin
                mid_next = mid_w[IW-1:0];
                if (!range_open) begin
                    pos_next = lo_reg;
                end
            end
            ST_COMPARE: begin
                if (rd_key < key_reg) begin
                    lo_next = CW'(mid_ext + 1'b1);
                end else if (rd_key > key_reg) begin
                    hi_next = mid_ext;
                end else begin
                    hit_next  = 1'b1;
                    pos_next  = mid_ext;
                    fpay_next = rd_pay;
                end
            end
            ST_DECIDE: begin
                pend_next = 1'b0;
                st_next   = STATUS_OK;
                case (func_reg)
                    FUNC_LOOKUP: begin
                        if (!hit_reg) begin
                            st_next   = STATUS_NOT_FOUND;
                            pos_next  = '0;
                            fpay_next = '0;
                        end
                    end
                    FUNC_INSERT: begin
                        fpay_next = '0;
                        if (hit_reg) begin
                            st_next = STATUS_DUPLICATE;
                        end else if (count_reg == CW'(TABLE_DEPTH)) begin
                            st_next  = STATUS_FULL;
                            pos_next = '0;
                        end else begin
                            ptr_next = count_reg;
                        end
                    end
                    FUNC_DELETE: begin
                        fpay_next = '0;
                        if (hit_reg) begin
                            ptr_next = pos_reg;
                        end else begin
                            st_next  = STATUS_NOT_FOUND;
                            pos_next = '0;
                        end
                    end
                    default: begin
                        pos_next  = '0;
                        fpay_next = '0;
                    end
                endcase
            end
            ST_SHIFT: begin
                pend_next = shift_more;
                if (shift_more) begin
                    dst_next = ptr_reg[IW-1:0];
                    ptr_next = shift_src;
                end
            end
            ST_FINISH: begin
                count_next = is_insert ? CW'(count_reg + 1'b1) : CW'(count_reg - 1'b1);
            end
            default: begin
                pend_next = pend_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg <= func_next;
        key_reg  <= key_next;
        pl_reg   <= pl_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        pos_reg  <= pos_next;
        ptr_reg  <= ptr_next;
        mid_reg  <= mid_next;
        dst_reg  <= dst_next;
        hit_reg  <= hit_next;
        st_reg   <= st_next;
        fpay_reg <= fpay_next;
    end

    always_comb begin
        res.status        = st_reg;
        res.found_index   = pos_wide[INDEX_OUT_W-1:0];
        res.found_payload = fpay_reg;
        res.count_out     = count_wide[COUNT_OUT_W-1:0];
    end

endmodule

[rtl/core/sorted_key_table.sv]
// Sorted key table with lookup, insert and delete on a stream interface.
// Each input beat on the s_ channel carries one operation, selected by s_tuser,
// and produces exactly one result beat on the m_ channel, in order.
// A lookup is a binary search over the stored entries: each probe reads one entry
// through the single table memory and compares its key, with at most
// ceil(log2(count + 1)) probes, followed by a decide step and the handoff.
// An insert or delete runs the same search and then moves every entry above the
// position by one place, one entry per cycle through the memory's read and
// write ports, then writes the new entry on an insert and updates the count.
// One operation is in flight at a time; s_tready is high while the engine is
// idle, and the next beat is taken while a finished result waits in the output
// register.
// When m_tready is low the result is held in the output register and the engine
// holds the following result until that register frees.
// Reset empties the table at once; the memory is not cleared, since only
// entries below the count are ever read.
module sorted_key_table #(
    parameter int TABLE_DEPTH = ska_pkg::DEFAULT_DEPTH,
    localparam int IW = $clog2(TABLE_DEPTH)
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // key[30:0], payload_in[61:31], zero fill
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // found_index[7:0], found_payload[38:8], count_out[47:39]
    output logic [1:0]  m_tuser    // status[1:0]
);

    import ska_pkg::*;

    `include "assert_macros.svh"

    req_t               req;
    res_t               res;
    logic               res_valid;
    logic               res_ready;
    logic               mem_rd_en;
    logic [IW-1:0]      mem_rd_addr;
    logic [ENTRY_W-1:0] mem_rd_data;
    logic               mem_wr_en;
    logic [IW-1:0]      mem_wr_addr;
    logic [ENTRY_W-1:0] mem_wr_data;

    logic               m_tvalid_reg, m_tvalid_next;
    res_t               m_res_reg, m_res_next;

    assign req.func       = func_t'(s_tuser);
    assign req.key        = s_tdata[KEY_W-1:0];
    assign req.payload_in = s_tdata[ENTRY_W-1:KEY_W];

    ska_engine #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req_valid  (s_tvalid),
        .req_ready  (s_tready),
        .req        (req),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .mem_rd_en  (mem_rd_en),
        .mem_rd_addr(mem_rd_addr),
        .mem_rd_data(mem_rd_data),
        .mem_wr_en  (mem_wr_en),
        .mem_wr_addr(mem_wr_addr),
        .mem_wr_data(mem_wr_data)
    );

    ska_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .aclk   (aclk),
        .wr_en  (mem_wr_en),
        .wr_addr(mem_wr_addr),
        .wr_data(mem_wr_data),
        .rd_en  (mem_rd_en),
        .rd_addr(mem_rd_addr),
        .rd_data(mem_rd_data)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_res_next    = m_res_reg;
        if (res_ready) begin
            m_tvalid_next = res_valid;
            if (res_valid) begin
                m_res_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_res_reg.status;
    assign m_tdata  = {m_res_reg.count_out, m_res_reg.found_payload, m_res_reg.found_index};

    `SKA_ASSERT(a_no_same_entry_rw, aclk, aresetn, !(mem_rd_en && mem_wr_en && (mem_rd_addr == mem_wr_addr)), "table read and write hit the same entry in one cycle")
    `SKA_ASSERT(a_result_held, aclk, aresetn, (res_valid && !res_ready) |=> res_valid, "pending result dropped while the output register was full")
    `SKA_ASSERT(a_idle_no_write, aclk, aresetn, s_tready |-> !mem_wr_en, "table written while the engine is idle")
    `SKA_ASSERT_ALWAYS(a_reset_state, aclk, !aresetn |=> (s_tready && !m_tvalid_reg), "engine not idle and empty after reset")

endmodule
